// ----- src/fbpg_pkg.sv -----
`timescale 1ns / 1ps

package fbpg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int PRI_W       = 24;
    localparam int HOP_COUNT_W = 5;
    localparam int LEN_W       = 16;
    localparam int FREQ_W      = 32;
    localparam int PULSE_W     = 24;
    localparam int CHIP_IDX_W  = 4;
    localparam int SEL_W       = 4;
    localparam int CODE_W      = 16;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_TYPE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRI_SAMPLES      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOP_COUNT        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBPULSE_SAMPLES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIP_SAMPLES     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BARKER_SELECT    = 3'd5;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic WAVE_FSK     = 1'b0;
    localparam logic WAVE_FSK_PSK = 1'b1;

    localparam logic [SEL_W-1:0] BARKER_LAST_SEL = 4'd8;

    // barker codes: length and a mask of the chips that are -1
    localparam logic [CHIP_IDX_W-1:0] CODE_LEN [9] = '{
        4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd7, 4'd11, 4'd13
    };
    localparam logic [CODE_W-1:0] CODE_NEG [9] = '{
        16'h0002, 16'h0000, 16'h0004, 16'h0004, 16'h0008,
        16'h0008, 16'h0058, 16'h05B8, 16'h0A60
    };

    // pi / 2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic                   waveform_type;
        logic [PRI_W-1:0]       pri_samples;
        logic [HOP_COUNT_W-1:0] hop_count;
        logic [LEN_W-1:0]       subpulse_samples;
        logic [LEN_W-1:0]       chip_samples;
        logic [SEL_W-1:0]       barker_select;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic negate;
    } samp_ctl_t;

    typedef struct packed {
        logic active;
        logic i_neg;
        logic q_neg;
    } rom_ctl_t;

    // Q30 sine by taylor series to x^13, every product truncated
    function automatic longint sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30))
        begin
            sum = longint'(1) << 30;
        end
        return sum;
    endfunction

endpackage

// ----- src/fbpg_sequencer.sv -----
`timescale 1ns / 1ps

module fbpg_sequencer
    import fbpg_pkg::*;
#(
    parameter int HOP_ENTRIES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 fire,
    input  logic                 mode,
    input  logic [3:0]           entry_index,
    input  logic [FREQ_W-1:0]    freq_word,
    input  logic [LEN_W-1:0]     hop_length,
    output logic [FREQ_W-1:0]    freq,
    output logic [PULSE_W-1:0]   sample_count,
    output samp_ctl_t            ctl
);

    localparam int HOP_IDX_W = (HOP_ENTRIES > 1) ? $clog2(HOP_ENTRIES) : 1;
    localparam int HOP_LIMIT = (HOP_ENTRIES < 31) ? HOP_ENTRIES : 31;

    logic [FREQ_W-1:0] freq_mem [HOP_ENTRIES];
    logic [LEN_W-1:0]  len_mem  [HOP_ENTRIES];
    logic [HOP_ENTRIES-1:0] nonzero_reg;
    logic [LEN_W-1:0]  len_cur_reg;

    logic [FREQ_W-1:0]  freq_reg;
    logic [PULSE_W-1:0] sample_reg;
    samp_ctl_t          ctl_reg;

    logic [PRI_W-1:0]       pri_position_reg, pri_position_next;
    logic [HOP_COUNT_W-1:0] hop_index_reg, hop_index_next;
    logic [LEN_W-1:0]       hop_sample_reg, hop_sample_next;
    logic [PULSE_W-1:0]     pulse_sample_reg, pulse_sample_next;
    logic [CHIP_IDX_W-1:0]  chip_index_reg, chip_index_next;
    logic [LEN_W-1:0]       chip_sample_reg, chip_sample_next;

    logic                   tick;
    logic                   write_en;
    logic [HOP_IDX_W-1:0]   wr_addr;
    logic [HOP_IDX_W-1:0]   rd_addr;
    logic                   psk;
    logic [SEL_W-1:0]       sel;
    logic [HOP_COUNT_W-1:0] hops;
    logic [HOP_COUNT_W-1:0] skip_target;
    logic [HOP_COUNT_W-1:0] target;
    logic [LEN_W-1:0]       len_first;
    logic                   in_range;
    logic                   stay;
    logic                   act;
    logic [LEN_W-1:0]       hs;
    logic [CHIP_IDX_W-1:0]  ci;
    logic [LEN_W-1:0]       cs;
    logic [LEN_W:0]         cs_inc;
    logic                   chip_step;
    logic                   negate;
    logic [PULSE_W-1:0]     n;
    logic [PRI_W-1:0]       pos_inc;
    logic [PRI_W-1:0]       pri_eff;
    logic                   restart;

    assign tick     = fire && (mode == MODE_TICK);
    assign write_en = fire && (mode == MODE_WRITE) && (int'(entry_index) < HOP_ENTRIES);
    assign wr_addr  = HOP_IDX_W'(entry_index);
    assign rd_addr  = HOP_IDX_W'(hop_index_next);

    always_comb
    begin
        psk  = cfg.waveform_type == WAVE_FSK_PSK;
        sel  = (cfg.barker_select > BARKER_LAST_SEL) ? BARKER_LAST_SEL : cfg.barker_select;
        hops = (cfg.hop_count < HOP_COUNT_W'(HOP_LIMIT)) ? cfg.hop_count
                                                          : HOP_COUNT_W'(HOP_LIMIT);
        len_first = psk ? cfg.subpulse_samples : len_cur_reg;
        in_range  = hop_index_reg < hops;
        stay      = in_range && (hop_sample_reg < len_first);

        // first later hop that is not empty, or the end of the pulse
        skip_target = hops;
        for (int k = HOP_LIMIT - 1; k >= 0; k--)
        begin
            if ((HOP_COUNT_W'(k) > hop_index_reg) && (HOP_COUNT_W'(k) < hops)
                && (psk ? (cfg.subpulse_samples != '0) : nonzero_reg[k]))
            begin
                skip_target = HOP_COUNT_W'(k);
            end
        end

        if (!in_range || stay)
        begin
            target = hop_index_reg;
            hs     = hop_sample_reg;
            ci     = chip_index_reg;
            cs     = chip_sample_reg;
        end
        else
        begin
            target = skip_target;
            hs     = '0;
            ci     = '0;
            cs     = '0;
        end

        act       = target < hops;
        n         = psk ? pulse_sample_reg : PULSE_W'(hs);
        chip_step = psk && (cfg.chip_samples != '0) && (ci < CODE_LEN[sel]);
        negate    = act && chip_step && CODE_NEG[sel][ci];
        cs_inc    = {1'b0, cs} + (LEN_W+1)'(1);

        pos_inc = pri_position_reg + PRI_W'(1);
        pri_eff = (cfg.pri_samples == '0) ? PRI_W'(1) : cfg.pri_samples;
        restart = (pos_inc >= pri_eff) || (pos_inc == '0);

        pri_position_next = pri_position_reg;
        hop_index_next    = hop_index_reg;
        hop_sample_next   = hop_sample_reg;
        pulse_sample_next = pulse_sample_reg;
        chip_index_next   = chip_index_reg;
        chip_sample_next  = chip_sample_reg;

        if (tick)
        begin
            hop_index_next   = target;
            hop_sample_next  = hs;
            chip_index_next  = ci;
            chip_sample_next = cs;
            if (act)
            begin
                hop_sample_next   = hs + LEN_W'(1);
                pulse_sample_next = pulse_sample_reg + PULSE_W'(1);
                if (chip_step)
                begin
                    if (cs_inc >= {1'b0, cfg.chip_samples})
                    begin
                        chip_sample_next = '0;
                        chip_index_next  = ci + CHIP_IDX_W'(1);
                    end
                    else
                    begin
                        chip_sample_next = cs_inc[LEN_W-1:0];
                    end
                end
            end
            pri_position_next = pos_inc;
            if (restart)
            begin
                pri_position_next = '0;
                hop_index_next    = '0;
                hop_sample_next   = '0;
                pulse_sample_next = '0;
                chip_index_next   = '0;
                chip_sample_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pri_position_reg <= '0;
            hop_index_reg    <= '0;
            hop_sample_reg   <= '0;
            pulse_sample_reg <= '0;
            chip_index_reg   <= '0;
            chip_sample_reg  <= '0;
        end
        else
        begin
            pri_position_reg <= pri_position_next;
            hop_index_reg    <= hop_index_next;
            hop_sample_reg   <= hop_sample_next;
            pulse_sample_reg <= pulse_sample_next;
            chip_index_reg   <= chip_index_next;
            chip_sample_reg  <= chip_sample_next;
        end
    end

    // hop table; the length of the current hop is kept read out ahead
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            freq_mem[wr_addr]    <= freq_word;
            len_mem[wr_addr]     <= hop_length;
            nonzero_reg[wr_addr] <= hop_length != '0;
        end
        if (write_en && (wr_addr == rd_addr))
        begin
            len_cur_reg <= hop_length;
        end
        else
        begin
            len_cur_reg <= len_mem[rd_addr];
        end
        if (tick)
        begin
            freq_reg       <= freq_mem[HOP_IDX_W'(target)];
            sample_reg     <= n;
            ctl_reg.active <= act;
            ctl_reg.negate <= negate;
        end
    end

    assign freq         = freq_reg;
    assign sample_count = sample_reg;
    assign ctl          = ctl_reg;

endmodule

// ----- src/fbpg_phase.sv -----
`timescale 1ns / 1ps

module fbpg_phase
    import fbpg_pkg::*;
#(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [FREQ_W-1:0]         freq,
    input  logic [PULSE_W-1:0]        sample_count,
    input  samp_ctl_t                 ctl_in,
    output logic [SINE_ADDR_BITS-1:0] addr,
    output samp_ctl_t                 ctl_out
);

    // only the low phase bits survive, so the product never needs more than 32 bits
    localparam int MUL_BITS = (PHASE_BITS < 32) ? PHASE_BITS : 32;
    localparam int PROD_W   = MUL_BITS + PULSE_W;

    logic [MUL_BITS-1:0]       fw;
    logic [PROD_W-1:0]         prod;
    logic [SINE_ADDR_BITS-1:0] addr_reg;
    samp_ctl_t                 ctl_reg;

    assign fw   = freq[FREQ_W-1 -: MUL_BITS];
    assign prod = PROD_W'(fw) * PROD_W'(sample_count);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            addr_reg <= prod[MUL_BITS-1 -: SINE_ADDR_BITS];
            ctl_reg  <= ctl_in;
        end
    end

    assign addr    = addr_reg;
    assign ctl_out = ctl_reg;

endmodule

// ----- src/fbpg_sine_rom.sv -----
`timescale 1ns / 1ps

module fbpg_sine_rom
    import fbpg_pkg::*;
#(
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [SINE_ADDR_BITS-1:0] addr,
    input  samp_ctl_t                 ctl_in,
    output logic [SAMPLE_BITS-2:0]    i_mag,
    output logic [SAMPLE_BITS-2:0]    q_mag,
    output rom_ctl_t                  ctl_out
);

    localparam int     QUARTER  = 1 << (SINE_ADDR_BITS - 2);
    localparam int     MAG_W    = SAMPLE_BITS - 1;
    localparam int     M_W      = SINE_ADDR_BITS - 1;
    localparam int     ROM_BITS = (QUARTER + 1) * MAG_W;
    localparam longint AMP      = (longint'(1) << MAG_W) - 1;

    // quarter wave, both ends included
    function automatic logic [ROM_BITS-1:0] build_rom();
        logic [ROM_BITS-1:0] rom;
        longint unsigned     x;
        longint              v;
        rom = '0;
        for (int m = 0; m <= QUARTER; m++)
        begin
            x = (HALF_PI_Q30 * 64'(m)) >> (SINE_ADDR_BITS - 2);
            v = (sine_q30(x) * AMP + (longint'(1) << 29)) >>> 30;
            if (v > AMP)
            begin
                v = AMP;
            end
            rom[m*MAG_W +: MAG_W] = MAG_W'(v);
        end
        return rom;
    endfunction

    localparam logic [ROM_BITS-1:0] SINE_ROM = build_rom();

    function automatic logic [M_W-1:0] fold(input logic [SINE_ADDR_BITS-1:0] a);
        logic [M_W-1:0] r;
        r = M_W'(a[SINE_ADDR_BITS-3:0]);
        return a[SINE_ADDR_BITS-2] ? (M_W'(QUARTER) - r) : r;
    endfunction

    logic [SINE_ADDR_BITS-1:0] addr_i;
    logic [MAG_W-1:0]          i_mag_reg, q_mag_reg;
    rom_ctl_t                  ctl_reg;

    // cosine is the sine a quarter turn on
    assign addr_i = addr + SINE_ADDR_BITS'(QUARTER);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_mag_reg      <= SINE_ROM[fold(addr_i)*MAG_W +: MAG_W];
            q_mag_reg      <= SINE_ROM[fold(addr)*MAG_W +: MAG_W];
            ctl_reg.active <= ctl_in.active;
            ctl_reg.i_neg  <= addr_i[SINE_ADDR_BITS-1] ^ ctl_in.negate;
            ctl_reg.q_neg  <= addr[SINE_ADDR_BITS-1] ^ ctl_in.negate;
        end
    end

    assign i_mag   = i_mag_reg;
    assign q_mag   = q_mag_reg;
    assign ctl_out = ctl_reg;

endmodule

// ----- src/fsk_barker_pulse_generator_top.sv -----
`timescale 1ns / 1ps

// Repeating radar pulse source: frequency hopping, optionally with a Barker
// phase code on each subpulse.
// Input channel (in_valid / in_ready): mode 0 is a sample tick and gives one
// output transaction; mode 1 writes hop table entry entry_index with
// freq_word and hop_length and gives none.
// Output channel (out_valid / out_ready): i_out, q_out as Q1.15 and
// pulse_active, zero samples during the off time.
// Configuration: cfg_write with cfg_index / cfg_data, one register per cycle,
// only while no tick is in flight.
// Throughput is one input transaction per cycle while in_ready is high. The
// accepting edge loads a tick into the sequencer register; it then passes the
// phase multiply, the sine table read and the output register, where it is valid.
// Reset clears the pulse and interval counters and loads the default
// registers; hop table contents are undefined until written.
// When the receiver stalls, the stages close up their bubbles and in_ready
// falls only once all four stages hold a result.

module fsk_barker_pulse_generator_top
    import fbpg_pkg::*;
#(
    parameter int HOP_ENTRIES    = 16,
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [3:0]                    entry_index,
    input  logic [FREQ_W-1:0]             freq_word,
    input  logic [LEN_W-1:0]              hop_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] i_out,
    output logic signed [SAMPLE_BITS-1:0] q_out,
    output logic                          pulse_active
);

    cfg_t cfg_reg;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4;
    logic fire, tick_fire;

    logic [FREQ_W-1:0]         s1_freq;
    logic [PULSE_W-1:0]        s1_count;
    samp_ctl_t                 s1_ctl;
    logic [SINE_ADDR_BITS-1:0] s2_addr;
    samp_ctl_t                 s2_ctl;
    logic [SAMPLE_BITS-2:0]    s3_i_mag, s3_q_mag;
    rom_ctl_t                  s3_ctl;

    logic [SAMPLE_BITS-1:0] i_ext, q_ext;
    logic [SAMPLE_BITS-1:0] i_val, q_val;
    logic [SAMPLE_BITS-1:0] i_out_reg, q_out_reg;
    logic                   active_reg;

    assign en4 = !out_valid_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready  = en1;
    assign fire      = in_valid && en1;
    assign tick_fire = fire && (mode == MODE_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveform_type    <= WAVE_FSK;
            cfg_reg.pri_samples      <= PRI_W'(1000);
            cfg_reg.hop_count        <= HOP_COUNT_W'(3);
            cfg_reg.subpulse_samples <= LEN_W'(100);
            cfg_reg.chip_samples     <= LEN_W'(7);
            cfg_reg.barker_select    <= BARKER_LAST_SEL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WAVEFORM_TYPE:    cfg_reg.waveform_type    <= cfg_data[0];
                REG_PRI_SAMPLES:      cfg_reg.pri_samples      <= cfg_data[PRI_W-1:0];
                REG_HOP_COUNT:        cfg_reg.hop_count        <= cfg_data[HOP_COUNT_W-1:0];
                REG_SUBPULSE_SAMPLES: cfg_reg.subpulse_samples <= cfg_data[LEN_W-1:0];
                REG_CHIP_SAMPLES:     cfg_reg.chip_samples     <= cfg_data[LEN_W-1:0];
                REG_BARKER_SELECT:    cfg_reg.barker_select    <= cfg_data[SEL_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= tick_fire;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    fbpg_sequencer #(
        .HOP_ENTRIES (HOP_ENTRIES)
    ) u_sequencer (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .fire         (fire),
        .mode         (mode),
        .entry_index  (entry_index),
        .freq_word    (freq_word),
        .hop_length   (hop_length),
        .freq         (s1_freq),
        .sample_count (s1_count),
        .ctl          (s1_ctl)
    );

    fbpg_phase #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_phase (
        .clk          (clk),
        .en           (en2),
        .freq         (s1_freq),
        .sample_count (s1_count),
        .ctl_in       (s1_ctl),
        .addr         (s2_addr),
        .ctl_out      (s2_ctl)
    );

    fbpg_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .en      (en3),
        .addr    (s2_addr),
        .ctl_in  (s2_ctl),
        .i_mag   (s3_i_mag),
        .q_mag   (s3_q_mag),
        .ctl_out (s3_ctl)
    );

    assign i_ext = {1'b0, s3_i_mag};
    assign q_ext = {1'b0, s3_q_mag};
    assign i_val = s3_ctl.i_neg ? -i_ext : i_ext;
    assign q_val = s3_ctl.q_neg ? -q_ext : q_ext;

    // off time gives zeros
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            i_out_reg  <= s3_ctl.active ? i_val : '0;
            q_out_reg  <= s3_ctl.active ? q_val : '0;
            active_reg <= s3_ctl.active;
        end
    end

    assign out_valid    = out_valid_reg;
    assign i_out        = i_out_reg;
    assign q_out        = q_out_reg;
    assign pulse_active = active_reg;

    a_off_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pulse_active |-> (i_out == '0) && (q_out == '0))
        else $error("off time sample is not zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (mode == MODE_TICK) |=> v1_reg)
        else $error("accepted tick did not enter the pipeline");

    a_no_full_scale_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (i_out != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
                   && (q_out != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("sample outside the symmetric range");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import fbpg_pkg::*;

    localparam int          LUT_BITS    = 10;
    localparam int          LUT_SIZE    = 1 << LUT_BITS;
    localparam int          LUT_QUARTER = LUT_SIZE / 4;
    localparam int          HOP_SLOTS   = 16;
    localparam int          SMP_W       = 16;
    localparam longint      AMPLITUDE   = 32767;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 8;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

    // barker codes: length, and a mask of the chips that flip the sample
    localparam int unsigned BARKER_LEN [9] = '{2, 2, 3, 4, 4, 5, 7, 11, 13};
    localparam logic [15:0] BARKER_NEG [9] = '{
        16'h0002, 16'h0000, 16'h0004, 16'h0004, 16'h0008,
        16'h0008, 16'h0058, 16'h05B8, 16'h0A60
    };

    typedef struct packed {
        logic signed [SMP_W-1:0] i;
        logic signed [SMP_W-1:0] q;
        logic                    active;
    } sample_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic                          mode         = MODE_TICK;
    logic [3:0]                    entry_index  = '0;
    logic [FREQ_W-1:0]             freq_word    = '0;
    logic [LEN_W-1:0]              hop_length   = '0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic signed [SMP_W-1:0]       i_out;
    logic signed [SMP_W-1:0]       q_out;
    logic                          pulse_active;

    // predictor copy of the registers, hop table and pulse counters
    logic                          cfg_wave;
    int unsigned                   cfg_pri;
    int unsigned                   cfg_hops;
    int unsigned                   cfg_sub;
    int unsigned                   cfg_chip;
    int unsigned                   cfg_sel;
    logic [31:0]                   hop_freq [HOP_SLOTS];
    logic [15:0]                   hop_len  [HOP_SLOTS];
    int unsigned                   pri_pos;
    int unsigned                   hop_idx;
    int unsigned                   hop_smp;
    int unsigned                   pulse_smp;
    int unsigned                   chip_idx;
    int unsigned                   chip_smp;
    int                            sine_lut [LUT_SIZE];

    sample_t                       expected_samples [$];
    sample_t                       want;
    sample_t                       seen;

    int                            errors       = 0;
    int                            n_ticks      = 0;
    int                            n_table_wr   = 0;
    int                            n_checked    = 0;
    int                            n_active     = 0;
    int                            n_settings   = 0;
    int                            quiet_cycles = 0;
    int                            burst_left   = 0;
    logic [9:0]                    stall_phase  = '0;

    fsk_barker_pulse_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .entry_index  (entry_index),
        .freq_word    (freq_word),
        .hop_length   (hop_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .i_out        (i_out),
        .q_out        (q_out),
        .pulse_active (pulse_active)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // q30 sine by taylor series up to x^13, truncating every product
    function automatic longint taylor_sine_q30(input longint unsigned x);
        longint unsigned sq;
        longint unsigned term;
        longint          sum;
        sq   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (longint'(1) << 30))
            sum = longint'(1) << 30;
        return sum;
    endfunction

    function automatic void fill_sine_lut();
        int              quad;
        int              r;
        int              m;
        longint unsigned x;
        longint          v;
        for (int a = 0; a < LUT_SIZE; a++)
        begin
            quad = a / LUT_QUARTER;
            r    = a % LUT_QUARTER;
            m    = (quad % 2 == 1) ? LUT_QUARTER - r : r;
            x    = (QUARTER_TURN_Q30 * longint'(m)) >> (LUT_BITS - 2);
            v    = (taylor_sine_q30(x) * AMPLITUDE + (longint'(1) << 29)) >>> 30;
            if (v > AMPLITUDE)
                v = AMPLITUDE;
            sine_lut[a] = (quad >= 2) ? -int'(v) : int'(v);
        end
    endfunction

    function automatic void restart_pulse();
        hop_idx   = 0;
        hop_smp   = 0;
        pulse_smp = 0;
        chip_idx  = 0;
        chip_smp  = 0;
    endfunction

    // one sample tick: advance the hop sequencer and work out the sample
    function automatic sample_t next_sample();
        sample_t         s;
        int unsigned     hops;
        int unsigned     sel;
        int unsigned     span;
        int unsigned     addr;
        int unsigned     pri;
        longint unsigned freq;
        longint unsigned count;
        longint unsigned phase;
        logic            searching;
        logic            flip;
        hops = (cfg_hops < HOP_SLOTS) ? cfg_hops : HOP_SLOTS;
        sel  = (cfg_sel > BARKER_LAST_SEL) ? BARKER_LAST_SEL : cfg_sel;
        // step over finished or empty hops
        searching = 1'b1;
        while (searching && hop_idx < hops)
        begin
            span = (cfg_wave == WAVE_FSK_PSK) ? cfg_sub : hop_len[hop_idx];
            if (hop_smp < span)
                searching = 1'b0;
            else
            begin
                hop_idx++;
                hop_smp  = 0;
                chip_idx = 0;
                chip_smp = 0;
            end
        end
        s        = '0;
        flip     = 1'b0;
        s.active = (hop_idx < hops);
        if (s.active)
        begin
            freq  = hop_freq[hop_idx];
            count = (cfg_wave == WAVE_FSK_PSK) ? pulse_smp : hop_smp;
            phase = (freq * count) & 64'hFFFF_FFFF;
            addr  = int'(phase >> (32 - LUT_BITS));
            s.i   = SMP_W'(sine_lut[(addr + LUT_QUARTER) % LUT_SIZE]);
            s.q   = SMP_W'(sine_lut[addr]);
            if (cfg_wave == WAVE_FSK_PSK && cfg_chip > 0 && chip_idx < BARKER_LEN[sel])
            begin
                flip = BARKER_NEG[sel][chip_idx];
                chip_smp++;
                if (chip_smp >= cfg_chip)
                begin
                    chip_smp = 0;
                    chip_idx++;
                end
            end
            if (flip)
            begin
                s.i = -s.i;
                s.q = -s.q;
            end
            hop_smp   = (hop_smp + 1) & 32'hFFFF;
            pulse_smp = (pulse_smp + 1) & 32'hFF_FFFF;
        end
        pri     = (cfg_pri == 0) ? 1 : cfg_pri;
        pri_pos = (pri_pos + 1) & 32'hFF_FFFF;
        if (pri_pos >= pri || pri_pos == 0)
        begin
            pri_pos = 0;
            restart_pulse();
        end
        return s;
    endfunction

    // track register writes and accepted input transactions, check outputs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WAVEFORM_TYPE:    cfg_wave = cfg_data[0];
                    REG_PRI_SAMPLES:      cfg_pri  = cfg_data[23:0];
                    REG_HOP_COUNT:        cfg_hops = cfg_data[4:0];
                    REG_SUBPULSE_SAMPLES: cfg_sub  = cfg_data[15:0];
                    REG_CHIP_SAMPLES:     cfg_chip = cfg_data[15:0];
                    REG_BARKER_SELECT:    cfg_sel  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_WRITE)
                begin
                    hop_freq[entry_index] = freq_word;
                    hop_len[entry_index]  = hop_length;
                    n_table_wr++;
                end
                else
                begin
                    expected_samples.push_back(next_sample());
                    n_ticks++;
                end
            end
            if (out_valid && out_ready)
            begin
                seen = '{i: i_out, q: q_out, active: pulse_active};
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected sample i=%0d q=%0d active=%0b",
                             $time, seen.i, seen.q, seen.active);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    n_checked++;
                    if (want.active)
                        n_active++;
                    if (want !== seen)
                    begin
                        errors++;
                        $display("%0t: sample mismatch: expected i=%0d q=%0d active=%0b,",
                                 $time, want.i, want.q, want.active,
                                 " got i=%0d q=%0d active=%0b",
                                 seen.i, seen.q, seen.active);
                    end
                end
            end
        end
    end

    // receiver back-pressure: free running, then random, then short and long stalls
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    out_ready <= (stall_phase[2:0] != 3'd7);
            default: out_ready <= !stall_phase[3];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d samples outstanding",
                     $time, QUIET_LIMIT, expected_samples.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // send one input transaction, opening a random gap between bursts
    task automatic send_item(input logic m, input logic [3:0] idx,
                             input logic [31:0] fw, input logic [15:0] hl);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        freq_word   <= fw;
        hop_length  <= hl;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait until the pipeline has emptied
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
    endtask

    task automatic apply_settings(input logic wave, input int unsigned pri,
                                  input int unsigned hops, input int unsigned sub,
                                  input int unsigned chip, input int unsigned sel);
        settle();
        write_reg(REG_WAVEFORM_TYPE, wave);
        write_reg(REG_PRI_SAMPLES, pri);
        write_reg(REG_HOP_COUNT, hops);
        write_reg(REG_SUBPULSE_SAMPLES, sub);
        write_reg(REG_CHIP_SAMPLES, chip);
        write_reg(REG_BARKER_SELECT, sel);
        @(negedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    // mostly sample ticks, with the odd hop table rewrite mixed in
    task automatic run_phase(input int n_items);
        logic [15:0] hl;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    hl = 16'($urandom_range(0, 65535));
                else
                    hl = 16'($urandom_range(0, 20));
                send_item(MODE_WRITE, 4'($urandom_range(0, 15)), $urandom, hl);
            end
            else
                send_item(MODE_TICK, 4'($urandom_range(0, 15)), $urandom, 16'($urandom));
        end
    endtask

    // every entry written first, with the frequency and length extremes
    task automatic test_table_load();
        logic [31:0] fw;
        logic [15:0] hl;
        for (int e = 0; e < HOP_SLOTS; e++)
        begin
            fw = $urandom;
            hl = 16'($urandom_range(1, 12));
            case (e)
                0: begin fw = 32'h0000_0000; hl = 16'd3; end
                1: begin fw = 32'hFFFF_FFFF; hl = 16'd0; end
                2: begin fw = 32'h4000_0000; hl = 16'd4; end
                3: begin fw = 32'h8000_0000; hl = 16'hFFFF; end
                default: ;
            endcase
            send_item(MODE_WRITE, 4'(e), fw, hl);
        end
    endtask

    // reset registers: three hops, the middle one empty, then off time
    task automatic test_fsk_first_pulse();
        repeat (9) send_item(MODE_TICK, 4'($urandom_range(0, 15)), $urandom, 16'($urandom));
    endtask

    task automatic test_fsk_hopping();
        apply_settings(WAVE_FSK, 60, 4, 100, 7, 8);
        run_phase(70);
        // pulse runs past the end of the interval
        apply_settings(WAVE_FSK, 25, 16, 100, 7, 8);
        run_phase(70);
        // zero interval behaves as one sample
        apply_settings(WAVE_FSK, 0, 2, 100, 7, 8);
        run_phase(40);
        // empty pulse
        apply_settings(WAVE_FSK, 30, 0, 100, 7, 8);
        run_phase(30);
        // hop count above the table size
        apply_settings(WAVE_FSK, 200, 31, 100, 7, 8);
        run_phase(70);
    endtask

    // every code select, the unused ones included, with a short unmodulated tail
    task automatic test_barker_codes();
        int unsigned sub;
        int unsigned len;
        for (int sel = 0; sel < 16; sel++)
        begin
            len = BARKER_LEN[(sel > BARKER_LAST_SEL) ? BARKER_LAST_SEL : sel];
            sub = $urandom_range(8, 40);
            apply_settings(WAVE_FSK_PSK, $urandom_range(30, 150), $urandom_range(1, 16),
                           sub, sub / len, sel);
            run_phase(35);
        end
    endtask

    task automatic test_chip_edges();
        // no chips: whole subpulse unmodulated
        apply_settings(WAVE_FSK_PSK, 90, 5, 12, 0, 6);
        run_phase(40);
        // chips longer than the subpulse
        apply_settings(WAVE_FSK_PSK, 80, 6, 6, 20, 7);
        run_phase(40);
        // zero length subpulse skips every hop
        apply_settings(WAVE_FSK_PSK, 40, 3, 0, 2, 2);
        run_phase(25);
        // chips fill the subpulse exactly
        apply_settings(WAVE_FSK_PSK, 100, 16, 13, 1, 8);
        run_phase(40);
        // every register but the hop count at its maximum
        apply_settings(WAVE_FSK_PSK, 24'hFF_FFFF, 16, 16'hFFFF, 16'hFFFF, 15);
        run_phase(40);
    endtask

    initial
    begin
        fill_sine_lut();
        cfg_wave = WAVE_FSK;
        cfg_pri  = 1000;
        cfg_hops = 3;
        cfg_sub  = 100;
        cfg_chip = 7;
        cfg_sel  = 8;
        pri_pos  = 0;
        restart_pulse();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_table_load();
        test_fsk_first_pulse();
        test_fsk_hopping();
        test_barker_codes();
        test_chip_edges();
        settle();

        $display("covered %0d ticks and %0d hop table writes over %0d register settings",
                 n_ticks, n_table_wr, n_settings);
        $display("checked %0d samples, %0d inside a pulse, %0d errors",
                 n_checked, n_active, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
